// File: hw/rtl/rtpf_pkg.sv
// Shared types, widths and codes of the resistive touch point filter.
`default_nettype none
package rtpf_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int COORD_W   = 9;
   localparam int JUMP_W    = 10;
   localparam int CSR_IDX_W = 3;
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 24;
   localparam int DIV_CNT_W = 5;
   localparam int MUL_A_W   = 20;

   localparam int DEF_SCREEN_SHORT = 240;
   localparam int DEF_SCREEN_LONG  = 320;

   // Pressure scale: 4096 * 100 folded into one integer factor.
   localparam logic [MUL_A_W-1:0] PRESS_SCALE = 20'd409600;
   localparam logic [SAMPLE_W-1:0] PRESS_MAX  = 12'hFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_RAW_X_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_X_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_Y_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_Y_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PRESS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_JUMP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION   = 3'd6;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RELEASED = 2'd1;
   localparam logic [1:0] ST_LIGHT    = 2'd2;
   localparam logic [1:0] ST_JUMP     = 2'd3;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/rtpf_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rtpf_div
   import rtpf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = div_req.den;
         quo_in  = div_req.num;
      end else if (busy_ff) begin
         // shift in the next numerator bit, subtract when it fits
         if (!diff[DIV_DEN_W]) begin
            rem_in = diff[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("division started while divider busy");

endmodule
`default_nettype wire

// File: hw/rtl/resistive_touch_point_filter_core.sv
// Top level of the resistive touch point filter: sequencer, state and ports.
//
//   channel  dir   handshake            payload
//   req      in    req_tvalid/tready    tdata: 8 samples, Z1, Z2; tuser: pen levels
//   rsp      out   rsp_tvalid/tready    tdata: x, y, pressure; tuser: valid, status
//   csr      in    csr_valid/csr_ready  csr_index, csr_data
//
// A fully pressed item runs three divisions on the shared divider, one for the pressure
// and one for each axis, between its transfer and the load of the result register;
// a pressure settled without division, or a flat or reversed axis, skips its division.
// A released or too-light item skips the axis mapping and rotation and goes to the last step.
// Reset is synchronous; it restores register defaults and clears filter state.
// req_tready is high only while idle; the last step holds until the result register is free.
`default_nettype none
module resistive_touch_point_filter_core
   import rtpf_pkg::*;
#(
   parameter int SCREEN_SHORT = DEF_SCREEN_SHORT,
   parameter int SCREEN_LONG  = DEF_SCREEN_LONG
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // x_sample_a..d, y_sample_a..d, pressure_z_one, pressure_z_two (12 bits each)
   input  wire logic [119:0]         req_tdata,
   // pen_down_before, pen_down_after
   input  wire logic [1:0]           req_tuser,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // screen_x (9), screen_y (9), pressure_level (12), zero pad (2)
   output logic [31:0]               rsp_tdata,
   // point_valid (1), status_code (2)
   output logic [2:0]                rsp_tuser,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SAMPLE_W-1:0]  csr_data
);

   localparam logic [COORD_W-1:0] W_MAX = COORD_W'(SCREEN_SHORT - 1);
   localparam logic [COORD_W-1:0] H_MAX = COORD_W'(SCREEN_LONG - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_PRESS, S_PMUL_NUM, S_PMUL_DEN, S_PDIV, S_PWAIT, S_DECIDE,
      S_MAP_MUL, S_MAP_DIV, S_MAP_WAIT, S_MAP_NEXT, S_ROTATE, S_FINAL
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [SAMPLE_W-1:0] raw_x_low_ff, raw_x_high_ff, raw_y_low_ff, raw_y_high_ff;
   logic [SAMPLE_W-1:0] min_press_ff;
   logic [JUMP_W-1:0]   max_jump_ff;
   logic [1:0]          rotation_ff;

   // filter state
   logic [COORD_W-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                have_prev_ff, have_prev_in;
   logic [1:0]          streak_ff, streak_in;
   logic [SAMPLE_W-1:0] last_press_ff, last_press_in;

   // item working registers
   logic [SAMPLE_W-1:0]  xavg_ff, xavg_in, yavg_ff, yavg_in;
   logic [SAMPLE_W-1:0]  z1_ff, z1_in, z2_ff, z2_in;
   logic                 pdb_ff, pdb_in, pda_ff, pda_in;
   logic                 axis_ff, axis_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [COORD_W-1:0]   sxm_ff, sxm_in, sym_ff, sym_in;
   logic [COORD_W-1:0]   px_ff, px_in, py_ff, py_in;
   logic [1:0]           status_ff, status_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;
   logic [2:0]           rsp_user_ff, rsp_user_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [SAMPLE_W+1:0]  sum_x, sum_y;
   logic [MUL_A_W-1:0]   mul_a;
   logic [SAMPLE_W-1:0]  mul_b;
   logic [DIV_NUM_W-1:0] mul_p;
   logic [SAMPLE_W-1:0]  map_v, map_lo, map_hi, map_c;
   logic [COORD_W-1:0]   map_span, map_res;
   logic                 map_res_ok;
   logic [COORD_W-1:0]   sx;
   logic [COORD_W:0]     dx, dy;
   logic [COORD_W+1:0]   move_len;
   logic                 jumped, out_free, acc_ok;

   rtpf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign sum_x = 14'(req_tdata[11:0]) + 14'(req_tdata[23:12])
                + 14'(req_tdata[35:24]) + 14'(req_tdata[47:36]);
   assign sum_y = 14'(req_tdata[59:48]) + 14'(req_tdata[71:60])
                + 14'(req_tdata[83:72]) + 14'(req_tdata[95:84]);

   assign mul_p = DIV_NUM_W'(mul_a * mul_b);

   // axis map operands: Y onto the short axis first, then X onto the long one
   always_comb begin
      map_v    = axis_ff ? xavg_ff : yavg_ff;
      map_lo   = axis_ff ? raw_x_low_ff : raw_y_low_ff;
      map_hi   = axis_ff ? raw_x_high_ff : raw_y_high_ff;
      map_span = axis_ff ? H_MAX : W_MAX;
      if (map_v < map_lo) begin
         map_c = map_lo;
      end else if (map_v > map_hi) begin
         map_c = map_hi;
      end else begin
         map_c = map_v;
      end
   end

   assign sx   = W_MAX - sxm_ff;
   assign dx   = (px_ff >= prev_x_ff) ? (COORD_W+1)'(px_ff - prev_x_ff)
                                      : (COORD_W+1)'(prev_x_ff - px_ff);
   assign dy   = (py_ff >= prev_y_ff) ? (COORD_W+1)'(py_ff - prev_y_ff)
                                      : (COORD_W+1)'(prev_y_ff - py_ff);
   assign move_len = (COORD_W+2)'(dx) + (COORD_W+2)'(dy);
   assign jumped = (max_jump_ff != '0) && have_prev_ff
                && (move_len > (COORD_W+2)'(max_jump_ff));

   always_comb begin
      state_in      = state_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      have_prev_in  = have_prev_ff;
      streak_in     = streak_ff;
      last_press_in = last_press_ff;
      xavg_in       = xavg_ff;
      yavg_in       = yavg_ff;
      z1_in         = z1_ff;
      z2_in         = z2_ff;
      pdb_in        = pdb_ff;
      pda_in        = pda_ff;
      axis_in       = axis_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      sxm_in        = sxm_ff;
      sym_in        = sym_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      mul_a         = '0;
      mul_b         = '0;
      map_res       = '0;
      map_res_ok    = 1'b0;
      acc_ok        = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = num_ff;
      div_req.den   = den_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               xavg_in  = sum_x[SAMPLE_W+1:2];
               yavg_in  = sum_y[SAMPLE_W+1:2];
               z1_in    = req_tdata[107:96];
               z2_in    = req_tdata[119:108];
               pdb_in   = req_tuser[0];
               pda_in   = req_tuser[1];
               state_in = S_PRESS;
            end
         end
         S_PRESS: begin
            if (!pdb_ff) begin
               state_in = S_DECIDE;
            end else if (z1_ff == '0 || xavg_ff == '0) begin
               last_press_in = '0;
               state_in      = S_DECIDE;
            end else if (z2_ff <= z1_ff) begin
               last_press_in = PRESS_MAX;
               state_in      = S_DECIDE;
            end else begin
               state_in = S_PMUL_NUM;
            end
         end
         S_PMUL_NUM: begin
            mul_a    = PRESS_SCALE;
            mul_b    = z1_ff;
            num_in   = mul_p;
            state_in = S_PMUL_DEN;
         end
         S_PMUL_DEN: begin
            mul_a    = MUL_A_W'(xavg_ff);
            mul_b    = z2_ff - z1_ff;
            den_in   = mul_p[DIV_DEN_W-1:0];
            state_in = S_PDIV;
         end
         S_PDIV: begin
            div_req.start = 1'b1;
            state_in      = S_PWAIT;
         end
         S_PWAIT: begin
            if (div_rsp.done) begin
               // saturate the quotient at full scale
               last_press_in = (|div_rsp.quot[DIV_NUM_W-1:SAMPLE_W])
                             ? PRESS_MAX : div_rsp.quot[SAMPLE_W-1:0];
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            axis_in = 1'b0;
            if (!pdb_ff || !pda_ff) begin
               status_in    = ST_RELEASED;
               have_prev_in = 1'b0;
               streak_in    = '0;
               state_in     = S_FINAL;
            end else if (min_press_ff != '0 && last_press_ff < min_press_ff) begin
               status_in = ST_LIGHT;
               state_in  = S_FINAL;
            end else begin
               status_in = ST_OK;
               state_in  = S_MAP_MUL;
            end
         end
         S_MAP_MUL: begin
            if (map_hi == map_lo) begin
               map_res_ok = 1'b1;
               state_in   = S_MAP_NEXT;
            end else if (map_lo > map_hi) begin
               // clamp leaves only the two ends of the axis
               map_res    = (map_v < map_lo) ? '0 : map_span;
               map_res_ok = 1'b1;
               state_in   = S_MAP_NEXT;
            end else begin
               mul_a    = MUL_A_W'(map_c - map_lo);
               mul_b    = SAMPLE_W'(map_span);
               num_in   = mul_p;
               den_in   = DIV_DEN_W'(map_hi - map_lo);
               state_in = S_MAP_DIV;
            end
         end
         S_MAP_DIV: begin
            div_req.start = 1'b1;
            state_in      = S_MAP_WAIT;
         end
         S_MAP_WAIT: begin
            if (div_rsp.done) begin
               map_res    = div_rsp.quot[COORD_W-1:0];
               map_res_ok = 1'b1;
               state_in   = S_MAP_NEXT;
            end
         end
         S_MAP_NEXT: begin
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = S_MAP_MUL;
            end else begin
               state_in = S_ROTATE;
            end
         end
         S_ROTATE: begin
            case (rotation_ff)
               2'd0: begin
                  px_in = sx;
                  py_in = sym_ff;
               end
               2'd1: begin
                  px_in = sym_ff;
                  py_in = W_MAX - sx;
               end
               2'd2: begin
                  px_in = W_MAX - sx;
                  py_in = H_MAX - sym_ff;
               end
               default: begin
                  px_in = H_MAX - sym_ff;
                  py_in = sx;
               end
            endcase
            state_in = S_FINAL;
         end
         S_FINAL: begin
            if (out_free) begin
               if (status_ff == ST_OK) begin
                  if (jumped && (streak_ff + 2'd1) != 2'd3) begin
                     streak_in = streak_ff + 2'd1;
                  end else begin
                     acc_ok       = 1'b1;
                     streak_in    = '0;
                     prev_x_in    = px_ff;
                     prev_y_in    = py_ff;
                     have_prev_in = 1'b1;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_user_in  = {acc_ok ? ST_OK
                                      : ((status_ff == ST_OK) ? ST_JUMP : status_ff),
                               acc_ok};
               rsp_data_in  = {2'b00, last_press_ff,
                               acc_ok ? py_ff : {COORD_W{1'b0}},
                               acc_ok ? px_ff : {COORD_W{1'b0}}};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (map_res_ok) begin
         if (axis_ff) begin
            sym_in = map_res;
         end else begin
            sxm_in = map_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         raw_x_low_ff  <= 12'd200;
         raw_x_high_ff <= 12'd3900;
         raw_y_low_ff  <= 12'd200;
         raw_y_high_ff <= 12'd3900;
         min_press_ff  <= '0;
         max_jump_ff   <= '0;
         rotation_ff   <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         have_prev_ff  <= 1'b0;
         streak_ff     <= '0;
         last_press_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         have_prev_ff  <= have_prev_in;
         streak_ff     <= streak_in;
         last_press_ff <= last_press_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_RAW_X_LOW:  raw_x_low_ff  <= csr_data;
               CSR_RAW_X_HIGH: raw_x_high_ff <= csr_data;
               CSR_RAW_Y_LOW:  raw_y_low_ff  <= csr_data;
               CSR_RAW_Y_HIGH: raw_y_high_ff <= csr_data;
               CSR_MIN_PRESS:  min_press_ff  <= csr_data;
               CSR_MAX_JUMP:   max_jump_ff   <= csr_data[JUMP_W-1:0];
               CSR_ROTATION:   rotation_ff   <= csr_data[1:0];
               default: ;
            endcase
         end
      end
      xavg_ff     <= xavg_in;
      yavg_ff     <= yavg_in;
      z1_ff       <= z1_in;
      z2_ff       <= z2_in;
      pdb_ff      <= pdb_in;
      pda_ff      <= pda_in;
      axis_ff     <= axis_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      sxm_ff      <= sxm_in;
      sym_ff      <= sym_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   a_streak_below_three: assert property (@(posedge clock) disable iff (reset)
      streak_ff != 2'd3)
      else $error("jump streak reached three without passing the point");
   a_valid_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff[0] |-> rsp_user_ff[2:1] == ST_OK)
      else $error("accepted point carries a reject status");
   a_reject_zero_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_user_ff[0] |-> rsp_data_ff[2*COORD_W-1:0] == '0)
      else $error("rejected point carries coordinates");
   a_accept_sets_prev: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINAL && out_free && acc_ok |=> have_prev_ff)
      else $error("accepted point not stored as previous point");

endmodule
`default_nettype wire

// File: verif/resistive_touch_point_filter_core_test.sv
// Self-checking testbench for the resistive touch point filter core.
`default_nettype none
module resistive_touch_point_filter_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rtpf_pkg::*;

   typedef struct packed {
      logic       point_valid;
      logic [1:0] status_code;
      logic [8:0] screen_x;
      logic [8:0] screen_y;
      logic [11:0] pressure_level;
   } touch_point_type;

   typedef struct {
      logic [11:0] xs [4];
      logic [11:0] ys [4];
      logic [11:0] z_one;
      logic [11:0] z_two;
      logic        pen_before;
      logic        pen_after;
   } touch_sample_type;

   class touch_scoreboard;
      logic [11:0] x_low = 200, x_high = 3900, y_low = 200, y_high = 3900;
      logic [11:0] press_floor = 0;
      logic [9:0]  jump_limit = 0;
      logic [1:0]  turn = 0;
      logic [8:0]  last_x = 0, last_y = 0;
      logic        last_known = 0;
      logic [1:0]  streak = 0;
      logic [11:0] held_pressure = 0;
      touch_point_type pending_points [$];
      int errors = 0;

      function void set_register(logic [2:0] idx, logic [11:0] val);
         case (idx)
            CSR_RAW_X_LOW:  x_low = val;
            CSR_RAW_X_HIGH: x_high = val;
            CSR_RAW_Y_LOW:  y_low = val;
            CSR_RAW_Y_HIGH: y_high = val;
            CSR_MIN_PRESS:  press_floor = val;
            CSR_MAX_JUMP:   jump_limit = val[9:0];
            CSR_ROTATION:   turn = val[1:0];
            default: ;
         endcase
      endfunction

      function logic [11:0] pressure_of(int unsigned z1, int unsigned z2, int unsigned xavg);
         longint unsigned q;
         if (z1 == 0 || xavg == 0) return 0;
         if (z2 <= z1) return PRESS_MAX;
         q = (64'd409600 * z1) / (longint'(xavg) * (z2 - z1));
         return q > 4095 ? PRESS_MAX : q[11:0];
      endfunction

      function longint map_coord(int unsigned v, int unsigned lo, int unsigned hi, longint span);
         longint c;
         if (v < lo) c = lo;
         else if (v > hi) c = hi;
         else c = v;
         if (hi == lo) return 0;
         return (c - longint'(lo)) * span / (longint'(hi) - longint'(lo));
      endfunction

      function void note_sample(touch_sample_type s);
         int unsigned sum_x, sum_y, xavg, yavg;
         longint w, h, sx, sy, px, py, dx, dy;
         touch_point_type p;
         sum_x = 0; sum_y = 0; px = 0; py = 0;
         w = 239; h = 319;
         for (int i = 0; i < 4; i++) begin
            sum_x += s.xs[i];
            sum_y += s.ys[i];
         end
         xavg = sum_x / 4;
         yavg = sum_y / 4;
         p = '0;
         p.status_code = ST_OK;
         if (!s.pen_before) p.status_code = ST_RELEASED;
         else begin
            held_pressure = pressure_of(s.z_one, s.z_two, xavg);
            if (!s.pen_after) p.status_code = ST_RELEASED;
         end
         if (p.status_code == ST_RELEASED) begin
            last_known = 0;
            streak = 0;
         end else if (press_floor > 0 && held_pressure < press_floor) begin
            p.status_code = ST_LIGHT;
         end else begin
            sx = w - map_coord(yavg, y_low, y_high, w);
            sy = map_coord(xavg, x_low, x_high, h);
            case (turn)
               2'd0: begin px = sx; py = sy; end
               2'd1: begin px = sy; py = w - sx; end
               2'd2: begin px = w - sx; py = h - sy; end
               default: begin px = h - sy; py = sx; end
            endcase
            if (jump_limit > 0 && last_known) begin
               dx = px - last_x;
               dy = py - last_y;
               if ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) > jump_limit) begin
                  streak = streak + 1;
                  if (streak < 3) p.status_code = ST_JUMP;
               end
            end
            if (p.status_code == ST_OK) begin
               streak = 0;
               last_x = px[8:0];
               last_y = py[8:0];
               last_known = 1;
               p.point_valid = 1;
               p.screen_x = px[8:0];
               p.screen_y = py[8:0];
            end
         end
         p.pressure_level = held_pressure;
         pending_points.push_back(p);
      endfunction

      function void check_point(touch_point_type got);
         touch_point_type want;
         if (pending_points.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending_points.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [31:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SAMPLE_W-1:0]  csr_data = '0;

   touch_scoreboard board = new();
   longint cycles = 0;

   resistive_touch_point_filter_core u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Check every result transfer; stall the result side at random.
   initial begin
      int gap;
      touch_point_type got;
      forever begin
         @(negedge clock);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (gap != 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         got.point_valid = rsp_tuser[0];
         got.status_code = rsp_tuser[2:1];
         got.screen_x = rsp_tdata[8:0];
         got.screen_y = rsp_tdata[17:9];
         got.pressure_level = rsp_tdata[29:18];
         board.check_point(got);
      end
   end

   task automatic write_register(logic [2:0] idx, logic [11:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.set_register(idx, val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain;
      while (board.pending_points.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic send_sample(touch_sample_type s, bit no_gap);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
      @(negedge clock);
      repeat (gap) @(negedge clock);
      req_tvalid <= 1;
      req_tdata <= {s.z_two, s.z_one, s.ys[3], s.ys[2], s.ys[1], s.ys[0],
                    s.xs[3], s.xs[2], s.xs[1], s.xs[0]};
      req_tuser <= {s.pen_after, s.pen_before};
      do @(posedge clock); while (!req_tready);
      board.note_sample(s);
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   // Random touch: mostly a real press near a wandering point.
   function automatic touch_sample_type random_sample(int cx, int cy, int mode);
      touch_sample_type s;
      int spread;
      spread = $urandom_range(0, 3) == 0 ? 400 : 20;
      for (int i = 0; i < 4; i++) begin
         if (mode == 0) begin
            s.xs[i] = 12'($urandom);
            s.ys[i] = 12'($urandom);
         end else begin
            s.xs[i] = 12'((cx + $urandom_range(0, spread)) % 4096);
            s.ys[i] = 12'((cy + $urandom_range(0, spread)) % 4096);
         end
      end
      s.z_one = $urandom_range(0, 9) == 0 ? 12'd0 : 12'($urandom);
      s.z_two = $urandom_range(0, 9) == 0 ? s.z_one : 12'($urandom);
      s.pen_before = $urandom_range(0, 9) != 0;
      s.pen_after = $urandom_range(0, 9) != 0;
      return s;
   endfunction

   function automatic touch_sample_type fixed_sample(logic [11:0] xv, logic [11:0] yv,
         logic [11:0] z1, logic [11:0] z2, logic pb, logic pa);
      touch_sample_type s;
      for (int i = 0; i < 4; i++) begin
         s.xs[i] = xv;
         s.ys[i] = yv;
      end
      s.z_one = z1; s.z_two = z2; s.pen_before = pb; s.pen_after = pa;
      return s;
   endfunction

   initial begin
      touch_sample_type s;
      int cx, cy;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: extremes, release paths, pressure corner cases, jumps.
      send_sample(fixed_sample(12'd0, 12'd0, 12'd0, 12'd0, 1, 1), 0);
      send_sample(fixed_sample(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1, 1), 0);
      send_sample(fixed_sample(12'd2000, 12'd2000, 12'd100, 12'd50, 1, 1), 0);
      send_sample(fixed_sample(12'd1, 12'd2000, 12'd4095, 12'd4094, 1, 1), 0);
      send_sample(fixed_sample(12'd2000, 12'd2000, 12'd1, 12'd4095, 1, 1), 0);
      send_sample(fixed_sample(12'd2000, 12'd2000, 12'd500, 12'd900, 0, 1), 0);
      send_sample(fixed_sample(12'd2000, 12'd2000, 12'd500, 12'd900, 1, 0), 0);
      send_sample(fixed_sample(12'd2000, 12'd2000, 12'd500, 12'd900, 0, 0), 0);
      s = fixed_sample(12'd100, 12'd3000, 12'd500, 12'd900, 1, 1);
      s.xs[0] = 12'd0; s.xs[1] = 12'd1; s.xs[2] = 12'd2; s.xs[3] = 12'd3;
      send_sample(s, 1);
      drain();
      write_register(CSR_MIN_PRESS, 12'd300);
      write_register(CSR_MAX_JUMP, 12'd10);
      send_sample(fixed_sample(12'd2000, 12'd2000, 12'd1, 12'd4000, 1, 1), 0);
      send_sample(fixed_sample(12'd2000, 12'd2000, 12'd900, 12'd1000, 1, 1), 0);
      for (int i = 0; i < 4; i++)
         send_sample(fixed_sample(12'd3800, 12'd300, 12'd900, 12'd1000, 1, 1), 0);
      send_sample(fixed_sample(12'd200, 12'd3800, 12'd900, 12'd1000, 1, 1), 0);
      drain();
      write_register(CSR_RAW_X_LOW, 12'd3000);
      write_register(CSR_RAW_X_HIGH, 12'd1000);
      write_register(CSR_RAW_Y_LOW, 12'd500);
      write_register(CSR_RAW_Y_HIGH, 12'd500);
      write_register(CSR_MIN_PRESS, 12'hFFF);
      write_register(CSR_MAX_JUMP, 12'h3FF);
      write_register(CSR_ROTATION, 12'd3);
      send_sample(fixed_sample(12'd2000, 12'd100, 12'd100, 12'd50, 1, 1), 0);
      send_sample(fixed_sample(12'd3500, 12'd900, 12'd100, 12'd50, 1, 1), 0);
      drain();

      // Random phases across register settings.
      for (int phase = 0; phase < 8; phase++) begin
         write_register(CSR_RAW_X_LOW, phase == 7 ? 12'd0 : 12'($urandom_range(0, 600)));
         write_register(CSR_RAW_X_HIGH, phase == 7 ? 12'hFFF : 12'($urandom_range(3400, 4095)));
         write_register(CSR_RAW_Y_LOW, phase == 6 ? 12'hFFF : 12'($urandom_range(0, 600)));
         write_register(CSR_RAW_Y_HIGH, phase == 6 ? 12'd0 : 12'($urandom_range(3400, 4095)));
         write_register(CSR_MIN_PRESS, phase % 3 == 0 ? 12'd0 : 12'($urandom_range(1, 600)));
         write_register(CSR_MAX_JUMP, phase % 4 == 0 ? 12'd0 : 12'($urandom_range(1, 60)));
         write_register(CSR_ROTATION, 12'(phase % 4));
         cx = $urandom_range(0, 3600);
         cy = $urandom_range(0, 3600);
         for (int i = 0; i < 88; i++) begin
            if ($urandom_range(0, 15) == 0) begin
               cx = $urandom_range(0, 3600);
               cy = $urandom_range(0, 3600);
            end
            send_sample(random_sample(cx, cy, $urandom_range(0, 9) == 0 ? 0 : 1),
                        (i / 20) % 2 == 1);
            // Hold the sender until the pipeline is empty once per phase.
            if (i == 40)
               while (board.pending_points.size() != 0) @(negedge clock);
         end
         drain();
      end

      drain();
      if (board.errors == 0 && board.pending_points.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: resistive_touch_point_filter_core.f
hw/rtl/rtpf_pkg.sv
hw/rtl/rtpf_div.sv
hw/rtl/resistive_touch_point_filter_core.sv
verif/resistive_touch_point_filter_core_test.sv
